// ===== rtl/core/segment_intersection_unit_macros.svh =====
// assertion macros for the segment intersection unit
`ifndef SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SGI_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SGI_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/sgi_pkg.sv =====
// shared types, constants and magnitude helpers for the segment intersection unit
package sgi_pkg;

    localparam int QW        = 64;
    localparam int IFRAC     = 32;
    localparam int DIV_STEPS = 96;

    typedef logic signed [QW-1:0] q_t;
    typedef logic [QW-1:0]        mag_t;

    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

    localparam q_t   Q_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam q_t   Q_MIN  = {1'b1, {(QW-1){1'b0}}};
    localparam mag_t TOPBIT = {1'b1, {(QW-1){1'b0}}};

    function automatic mag_t mag_of(q_t v);
        return v[QW-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic q_t from_mag(logic neg, mag_t m);
        if (neg)
        begin
            return m[QW-1] ? Q_MIN : -q_t'(m);
        end
        return m[QW-1] ? Q_MAX : q_t'(m);
    endfunction

endpackage

// ===== rtl/core/sgi_if.sv =====
// handshake channels of the segment intersection unit
interface sgi_pair_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_a_start_x;
    logic signed [COORD_WIDTH-1:0] seg_a_start_y;
    logic signed [COORD_WIDTH-1:0] seg_a_end_x;
    logic signed [COORD_WIDTH-1:0] seg_a_end_y;
    logic signed [COORD_WIDTH-1:0] seg_b_start_x;
    logic signed [COORD_WIDTH-1:0] seg_b_start_y;
    logic signed [COORD_WIDTH-1:0] seg_b_end_x;
    logic signed [COORD_WIDTH-1:0] seg_b_end_y;

    modport source (
        output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        input  ready
    );
    modport sink (
        input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
        output ready
    );
endinterface

interface sgi_result_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          parallel;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
    logic                          clamped;

    modport source (
        output valid, hit, parallel, cross_x, cross_y, clamped,
        input  ready
    );
    modport sink (
        input  valid, hit, parallel, cross_x, cross_y, clamped,
        output ready
    );
endinterface

// ===== rtl/core/sgi_div.sv =====
// pipelined q32.32 saturating divider, one quotient bit per stage
module sgi_div #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sgi_pkg::stage_ctl_t ctl,
    input  sgi_pkg::q_t         num,
    input  sgi_pkg::q_t         den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid,
    output sgi_pkg::q_t         quo,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int N  = sgi_pkg::DIV_STEPS;
    localparam int QW = sgi_pkg::QW;

    logic              v_reg    [0:N];
    sgi_pkg::mag_t     na_reg   [0:N];
    sgi_pkg::mag_t     nb_reg   [0:N];
    sgi_pkg::mag_t     r_reg    [0:N];
    sgi_pkg::mag_t     q_reg    [0:N];
    logic              ovf_reg  [0:N];
    logic              neg_reg  [0:N];
    logic              zero_reg [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    logic              out_v_reg;
    sgi_pkg::q_t       quo_reg;
    logic [SIDE_W-1:0] side_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            na_reg[0]   <= sgi_pkg::mag_of(num);
            nb_reg[0]   <= sgi_pkg::mag_of(den);
            r_reg[0]    <= '0;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= 1'b0;
            neg_reg[0]  <= num[QW-1] ^ den[QW-1];
            zero_reg[0] <= (den == '0);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic          din;
        logic [QW:0]   rs;
        logic [QW:0]   diff;
        logic          ge;

        // dividend bits enter first, then the 32 fraction zeros
        if (k < QW)
        begin : g_bit
            assign din = na_reg[k][QW-1-k];
        end
        else
        begin : g_zero
            assign din = 1'b0;
        end

        assign rs   = {r_reg[k], din};
        assign diff = rs - {1'b0, nb_reg[k]};
        assign ge   = !diff[QW];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                na_reg[k+1]   <= na_reg[k];
                nb_reg[k+1]   <= nb_reg[k];
                r_reg[k+1]    <= ge ? diff[QW-1:0] : rs[QW-1:0];
                q_reg[k+1]    <= {q_reg[k][QW-2:0], ge};
                ovf_reg[k+1]  <= ovf_reg[k] | q_reg[k][QW-1];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            out_v_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (zero_reg[N])
            begin
                quo_reg <= '0;
            end
            else
            begin
                quo_reg <= sgi_pkg::from_mag(neg_reg[N],
                                             ovf_reg[N] ? sgi_pkg::TOPBIT : q_reg[N]);
            end
            side_out_reg <= side_reg[N];
        end
    end

    assign valid    = out_v_reg;
    assign quo      = quo_reg;
    assign side_out = side_out_reg;

endmodule

// ===== rtl/core/sgi_mul.sv =====
// four-stage q32.32 saturating multiplier built from 32x32 partial products
module sgi_mul #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sgi_pkg::stage_ctl_t ctl,
    input  sgi_pkg::q_t         a,
    input  sgi_pkg::q_t         b,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid,
    output sgi_pkg::q_t         prod,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int NS = 4;

    logic              v_reg    [0:NS-1];
    logic              neg_reg  [0:NS-1];
    logic [SIDE_W-1:0] side_reg [0:NS-1];

    sgi_pkg::mag_t ma_reg;
    sgi_pkg::mag_t mb_reg;
    logic [63:0]   p0_reg;
    logic [63:0]   p1_reg;
    logic [63:0]   p2_reg;
    logic [63:0]   p3_reg;
    logic [33:0]   mid_reg;
    logic [65:0]   hi_reg;
    sgi_pkg::q_t   prod_reg;

    logic [65:0]   hi_full;
    sgi_pkg::mag_t m_sat;

    always_comb
    begin
        hi_full = hi_reg + 66'(mid_reg[33:32]);
        if (hi_full > 66'hFFFF_FFFF)
        begin
            m_sat = sgi_pkg::TOPBIT;
        end
        else
        begin
            m_sat = {hi_full[31:0], mid_reg[31:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
            for (int i = 1; i < NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ma_reg      <= sgi_pkg::mag_of(a);
            mb_reg      <= sgi_pkg::mag_of(b);
            neg_reg[0]  <= a[63] ^ b[63];
            side_reg[0] <= side_in;
            for (int i = 1; i < NS; i++)
            begin
                neg_reg[i]  <= neg_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
            p0_reg   <= ma_reg[31:0]  * mb_reg[31:0];
            p1_reg   <= ma_reg[31:0]  * mb_reg[63:32];
            p2_reg   <= ma_reg[63:32] * mb_reg[31:0];
            p3_reg   <= ma_reg[63:32] * mb_reg[63:32];
            mid_reg  <= 34'(p0_reg[63:32]) + 34'(p1_reg[31:0]) + 34'(p2_reg[31:0]);
            hi_reg   <= 66'(p3_reg) + 66'(p1_reg[63:32]) + 66'(p2_reg[63:32]);
            prod_reg <= sgi_pkg::from_mag(neg_reg[NS-2], m_sat);
        end
    end

    assign valid    = v_reg[NS-1];
    assign prod     = prod_reg;
    assign side_out = side_reg[NS-1];

endmodule

// ===== rtl/core/segment_intersection_unit.sv =====
// Segment intersection unit: takes a word of two segments (four endpoints, signed fixed
// point with FRAC_BITS fraction bits) and returns one result word per input word: the
// crossing point of the two lines, a parallel flag, a hit flag when the crossing lies in
// both segments' spans, and a clamp flag. Internal math is saturating Q32.32. The unit
// takes one word every cycle while not stalled; most of its pipeline lies in the 96-stage
// bit-per-stage dividers (two for the slopes, then one for crossing x). The whole pipeline stalls
// together when the output register holds a word that is not taken.
module segment_intersection_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sgi_pair_if.sink     pair,
    sgi_result_if.source result
);

    localparam int SH = sgi_pkg::IFRAC - FRAC_BITS;

    typedef sgi_pkg::q_t q_t;

    typedef struct packed {
        q_t x1;
        q_t y1;
        q_t x2;
        q_t y2;
    } seg_t;

    typedef struct packed {
        seg_t seg;
        q_t   vert;
        logic vflag;
    } sl_side_t;

    typedef struct packed {
        seg_t seg;
        q_t   slope;
    } ic_side_t;

    typedef struct packed {
        seg_t a;
        seg_t b;
        q_t   sa;
        q_t   ca;
        logic par;
    } px_side_t;

    typedef struct packed {
        seg_t a;
        seg_t b;
        q_t   ca;
        q_t   px;
        logic par;
    } py_side_t;

    function automatic q_t sat96(logic signed [95:0] e);
        if (&e[95:63] || ~|e[95:63])
        begin
            return e[63:0];
        end
        return e[95] ? sgi_pkg::Q_MIN : sgi_pkg::Q_MAX;
    endfunction

    function automatic q_t widen(logic signed [COORD_WIDTH-1:0] c);
        logic signed [95:0] e;
        e = 96'(c) <<< SH;
        return sat96(e);
    endfunction

    function automatic q_t sat_add(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? sgi_pkg::Q_MIN : sgi_pkg::Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t sat_sub(q_t a, q_t b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? sgi_pkg::Q_MIN : sgi_pkg::Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic in_span(q_t p, q_t e1, q_t e2);
        if (e1 <= e2)
        begin
            return (p >= e1) && (p <= e2);
        end
        return (p <= e1) && (p >= e2);
    endfunction

    logic en;
    assign en         = !result.valid || result.ready;
    assign pair.ready = en;

    // widen, differences, vertical slope
    logic v1_reg, v2_reg, v3_reg;
    seg_t seg_a1_reg, seg_b1_reg, seg_a2_reg, seg_b2_reg, seg_a3_reg, seg_b3_reg;
    q_t   dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    q_t   dxa3_reg, dya3_reg, dxb3_reg, dyb3_reg;
    q_t   vert_a3_reg, vert_b3_reg;

    // slope, intercept, crossing setup
    logic v4_reg, v5_reg, v6_reg, v7_reg;
    seg_t seg_a4_reg, seg_b4_reg, seg_a5_reg, seg_b5_reg;
    seg_t seg_a6_reg, seg_b6_reg, seg_a7_reg, seg_b7_reg;
    q_t   slope_a4_reg, slope_b4_reg;
    q_t   sa5_reg, sb5_reg, ca5_reg, cb5_reg;
    q_t   sa6_reg, ca6_reg, num6_reg, den6_reg;
    logic par6_reg, par7_reg;
    q_t   px7_reg, py7_reg;

    // output register
    logic                          out_v_reg;
    logic                          hit_reg;
    logic                          par_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg;
    logic signed [COORD_WIDTH-1:0] cy_reg;
    logic                          clamp_reg;

    sl_side_t sl_a_in, sl_b_in, sl_a_out, sl_b_out;
    ic_side_t ic_a_in, ic_b_in, ic_a_out, ic_b_out;
    px_side_t px_in, px_out;
    py_side_t py_in, py_out;
    logic     div_a_v, div_b_v, mul_a_v, mul_b_v, div_p_v, mul_q_v;
    q_t       quo_a, quo_b, prod_a, prod_b, quo_p, prod_q;

    logic signed [95:0] va_wide, vb_wide;

    // dy * 1000 as shifts and subtracts
    assign va_wide = (96'(dya2_reg) <<< 10) - (96'(dya2_reg) <<< 4) - (96'(dya2_reg) <<< 3);
    assign vb_wide = (96'(dyb2_reg) <<< 10) - (96'(dyb2_reg) <<< 4) - (96'(dyb2_reg) <<< 3);

    assign sl_a_in = '{seg: seg_a3_reg, vert: vert_a3_reg, vflag: (dxa3_reg == '0)};
    assign sl_b_in = '{seg: seg_b3_reg, vert: vert_b3_reg, vflag: (dxb3_reg == '0)};

    sgi_div #(.SIDE_W($bits(sl_side_t))) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: v3_reg}),
        .num      (dya3_reg),
        .den      (dxa3_reg),
        .side_in  (sl_a_in),
        .valid    (div_a_v),
        .quo      (quo_a),
        .side_out (sl_a_out)
    );

    sgi_div #(.SIDE_W($bits(sl_side_t))) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: v3_reg}),
        .num      (dyb3_reg),
        .den      (dxb3_reg),
        .side_in  (sl_b_in),
        .valid    (div_b_v),
        .quo      (quo_b),
        .side_out (sl_b_out)
    );

    assign ic_a_in = '{seg: seg_a4_reg, slope: slope_a4_reg};
    assign ic_b_in = '{seg: seg_b4_reg, slope: slope_b4_reg};

    sgi_mul #(.SIDE_W($bits(ic_side_t))) u_mul_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: v4_reg}),
        .a        (seg_a4_reg.x1),
        .b        (slope_a4_reg),
        .side_in  (ic_a_in),
        .valid    (mul_a_v),
        .prod     (prod_a),
        .side_out (ic_a_out)
    );

    sgi_mul #(.SIDE_W($bits(ic_side_t))) u_mul_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: v4_reg}),
        .a        (seg_b4_reg.x1),
        .b        (slope_b4_reg),
        .side_in  (ic_b_in),
        .valid    (mul_b_v),
        .prod     (prod_b),
        .side_out (ic_b_out)
    );

    assign px_in = '{a: seg_a6_reg, b: seg_b6_reg, sa: sa6_reg, ca: ca6_reg, par: par6_reg};

    sgi_div #(.SIDE_W($bits(px_side_t))) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: v6_reg}),
        .num      (num6_reg),
        .den      (den6_reg),
        .side_in  (px_in),
        .valid    (div_p_v),
        .quo      (quo_p),
        .side_out (px_out)
    );

    assign py_in = '{a: px_out.a, b: px_out.b, ca: px_out.ca, px: quo_p, par: px_out.par};

    sgi_mul #(.SIDE_W($bits(py_side_t))) u_mul_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, valid: div_p_v}),
        .a        (quo_p),
        .b        (px_out.sa),
        .side_in  (py_in),
        .valid    (mul_q_v),
        .prod     (prod_q),
        .side_out (py_out)
    );

    // output conversion: floor shift back to FRAC_BITS, clamp to the coordinate range
    logic signed [63:0]            sx, sy;
    logic                          cx_over, cy_over;
    logic signed [COORD_WIDTH-1:0] cx_next, cy_next;
    logic                          hit_next;

    always_comb
    begin
        sx      = px7_reg >>> SH;
        sy      = py7_reg >>> SH;
        cx_over = !(&sx[63:COORD_WIDTH-1] || ~|sx[63:COORD_WIDTH-1]);
        cy_over = !(&sy[63:COORD_WIDTH-1] || ~|sy[63:COORD_WIDTH-1]);
        if (cx_over)
        begin
            cx_next = sx[63] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else
        begin
            cx_next = sx[COORD_WIDTH-1:0];
        end
        if (cy_over)
        begin
            cy_next = sy[63] ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else
        begin
            cy_next = sy[COORD_WIDTH-1:0];
        end
        hit_next = in_span(px7_reg, seg_a7_reg.x1, seg_a7_reg.x2)
                && in_span(py7_reg, seg_a7_reg.y1, seg_a7_reg.y2)
                && in_span(px7_reg, seg_b7_reg.x1, seg_b7_reg.x2)
                && in_span(py7_reg, seg_b7_reg.y1, seg_b7_reg.y2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= pair.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= div_a_v && div_b_v;
            v5_reg    <= mul_a_v && mul_b_v;
            v6_reg    <= v5_reg;
            v7_reg    <= mul_q_v;
            out_v_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_a1_reg <= '{x1: widen(pair.seg_a_start_x), y1: widen(pair.seg_a_start_y),
                            x2: widen(pair.seg_a_end_x),   y2: widen(pair.seg_a_end_y)};
            seg_b1_reg <= '{x1: widen(pair.seg_b_start_x), y1: widen(pair.seg_b_start_y),
                            x2: widen(pair.seg_b_end_x),   y2: widen(pair.seg_b_end_y)};

            seg_a2_reg <= seg_a1_reg;
            seg_b2_reg <= seg_b1_reg;
            dxa2_reg   <= sat_sub(seg_a1_reg.x2, seg_a1_reg.x1);
            dya2_reg   <= sat_sub(seg_a1_reg.y2, seg_a1_reg.y1);
            dxb2_reg   <= sat_sub(seg_b1_reg.x2, seg_b1_reg.x1);
            dyb2_reg   <= sat_sub(seg_b1_reg.y2, seg_b1_reg.y1);

            seg_a3_reg  <= seg_a2_reg;
            seg_b3_reg  <= seg_b2_reg;
            dxa3_reg    <= dxa2_reg;
            dya3_reg    <= dya2_reg;
            dxb3_reg    <= dxb2_reg;
            dyb3_reg    <= dyb2_reg;
            vert_a3_reg <= sat96(va_wide);
            vert_b3_reg <= sat96(vb_wide);

            // vertical segment takes dy * 1000 instead of the quotient
            seg_a4_reg   <= sl_a_out.seg;
            seg_b4_reg   <= sl_b_out.seg;
            slope_a4_reg <= sl_a_out.vflag ? sl_a_out.vert : quo_a;
            slope_b4_reg <= sl_b_out.vflag ? sl_b_out.vert : quo_b;

            seg_a5_reg <= ic_a_out.seg;
            seg_b5_reg <= ic_b_out.seg;
            sa5_reg    <= ic_a_out.slope;
            sb5_reg    <= ic_b_out.slope;
            ca5_reg    <= sat_sub(ic_a_out.seg.y1, prod_a);
            cb5_reg    <= sat_sub(ic_b_out.seg.y1, prod_b);

            seg_a6_reg <= seg_a5_reg;
            seg_b6_reg <= seg_b5_reg;
            sa6_reg    <= sa5_reg;
            ca6_reg    <= ca5_reg;
            par6_reg   <= (sa5_reg == sb5_reg);
            num6_reg   <= sat_sub(cb5_reg, ca5_reg);
            den6_reg   <= sat_sub(sa5_reg, sb5_reg);

            seg_a7_reg <= py_out.a;
            seg_b7_reg <= py_out.b;
            par7_reg   <= py_out.par;
            px7_reg    <= py_out.px;
            py7_reg    <= sat_add(prod_q, py_out.ca);

            par_reg <= par7_reg;
            if (par7_reg)
            begin
                hit_reg   <= 1'b0;
                cx_reg    <= '0;
                cy_reg    <= '0;
                clamp_reg <= 1'b0;
            end
            else
            begin
                hit_reg   <= hit_next;
                cx_reg    <= cx_next;
                cy_reg    <= cy_next;
                clamp_reg <= cx_over || cy_over;
            end
        end
    end

    assign result.valid    = out_v_reg;
    assign result.hit      = hit_reg;
    assign result.parallel = par_reg;
    assign result.cross_x  = cx_reg;
    assign result.cross_y  = cy_reg;
    assign result.clamped  = clamp_reg;

`include "segment_intersection_unit_macros.svh"

    `SGI_ASSERT_IMP(a_parallel_empty, result.valid && result.parallel, !result.hit && result.cross_x == '0 && result.cross_y == '0 && !result.clamped, "parallel word carries a crossing")
    `SGI_ASSERT_IMP(a_hit_unclamped, result.valid && result.hit, !result.clamped, "hit word was clamped")
    `SGI_ASSERT_NXT(a_stall_holds_slope, !en && v4_reg, v4_reg && $stable(slope_a4_reg) && $stable(slope_b4_reg), "slope stage moved during a stall")

endmodule

// ===== tb/tb_segment_intersection_unit.sv =====
// self-checking testbench for the segment intersection unit
`timescale 1ns / 100ps

module tb_segment_intersection_unit;

    typedef sgi_pkg::q_t   q_t;
    typedef sgi_pkg::mag_t mag_t;

    localparam int CW         = 32;
    localparam int FB         = 16;
    localparam int LATENCY    = 212;
    localparam int N_RANDOM   = 1400;
    localparam int CYCLE_CAP  = 400000;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        logic   parallel;
        coord_t cx;
        coord_t cy;
        logic   clamped;
    } crossing_t;

    typedef struct {
        seg_pair_t pr;
        logic      fixed;
        crossing_t res;
    } vec_t;

    logic clk;
    logic rst_n;
    sgi_pair_if   #(.COORD_WIDTH(CW)) pair_ch ();
    sgi_result_if #(.COORD_WIDTH(CW)) res_ch ();

    segment_intersection_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (res_ch.source)
    );

    crossing_t pending_crossings[$];
    int        mismatches;
    int        cycles;
    bit        stim_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---- saturating Q32.32 arithmetic ----
    function automatic q_t qadd(q_t a, q_t b);
        logic signed [sgi_pkg::QW:0] s;
        s = {a[sgi_pkg::QW-1], a} + {b[sgi_pkg::QW-1], b};
        if (s > $signed({1'b0, sgi_pkg::Q_MAX})) return sgi_pkg::Q_MAX;
        if (s < $signed({1'b1, sgi_pkg::Q_MIN})) return sgi_pkg::Q_MIN;
        return s[sgi_pkg::QW-1:0];
    endfunction

    function automatic q_t qsub(q_t a, q_t b);
        logic signed [sgi_pkg::QW:0] s;
        s = {a[sgi_pkg::QW-1], a} - {b[sgi_pkg::QW-1], b};
        if (s > $signed({1'b0, sgi_pkg::Q_MAX})) return sgi_pkg::Q_MAX;
        if (s < $signed({1'b1, sgi_pkg::Q_MIN})) return sgi_pkg::Q_MIN;
        return s[sgi_pkg::QW-1:0];
    endfunction

    function automatic mag_t magn(q_t v);
        return v[sgi_pkg::QW-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic q_t signed_sat(logic neg, mag_t m);
        if (neg)
            return m[sgi_pkg::QW-1] ? sgi_pkg::Q_MIN : -q_t'(m);
        return m[sgi_pkg::QW-1] ? sgi_pkg::Q_MAX : q_t'(m);
    endfunction

    function automatic q_t qmul(q_t a, q_t b);
        logic [127:0] p;
        mag_t m;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> sgi_pkg::IFRAC;
        m = (p[127:64] != 0) ? sgi_pkg::TOPBIT : p[63:0];
        return signed_sat(a[sgi_pkg::QW-1] != b[sgi_pkg::QW-1], m);
    endfunction

    function automatic q_t qdiv(q_t a, q_t b);
        logic [127:0] num;
        logic [127:0] quo;
        mag_t m;
        if (magn(b) == 0) return '0;
        num = {64'd0, magn(a)} << sgi_pkg::IFRAC;
        quo = num / {64'd0, magn(b)};
        m = (quo[127:64] != 0) ? sgi_pkg::TOPBIT : quo[63:0];
        return signed_sat(a[sgi_pkg::QW-1] != b[sgi_pkg::QW-1], m);
    endfunction

    function automatic q_t widen(coord_t c);
        logic signed [sgi_pkg::QW:0] w;
        w = $signed({{(sgi_pkg::QW+1-CW){c[CW-1]}}, c}) <<< (sgi_pkg::IFRAC - FB);
        if (w > $signed({1'b0, sgi_pkg::Q_MAX})) return sgi_pkg::Q_MAX;
        if (w < $signed({1'b1, sgi_pkg::Q_MIN})) return sgi_pkg::Q_MIN;
        return w[sgi_pkg::QW-1:0];
    endfunction

    function automatic logic in_range(q_t p, q_t e1, q_t e2);
        if (e1 <= e2) return p >= e1 && p <= e2;
        return p <= e1 && p >= e2;
    endfunction

    function automatic coord_t narrow(q_t v, inout logic clip);
        q_t s;
        s = v >>> (sgi_pkg::IFRAC - FB);
        if (s > q_t'(C_MAX)) begin clip = 1'b1; return C_MAX; end
        if (s < q_t'(C_MIN)) begin clip = 1'b1; return C_MIN; end
        return s[CW-1:0];
    endfunction

    function automatic void line_of(input q_t x1, y1, x2, y2, output q_t slope,
                                    output q_t icpt);
        q_t dx;
        q_t dy;
        dx = qsub(x2, x1);
        dy = qsub(y2, y1);
        if (dx == 0)
            slope = qmul(dy, q_t'(64'sd1000 <<< sgi_pkg::IFRAC));
        else
            slope = qdiv(dy, dx);
        icpt = qsub(y1, qmul(x1, slope));
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        q_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        q_t sa, ca, sb, cb, px, py;
        crossing_t r;
        logic clip;
        ax1 = widen(s.ax1); ay1 = widen(s.ay1); ax2 = widen(s.ax2); ay2 = widen(s.ay2);
        bx1 = widen(s.bx1); by1 = widen(s.by1); bx2 = widen(s.bx2); by2 = widen(s.by2);
        line_of(ax1, ay1, ax2, ay2, sa, ca);
        line_of(bx1, by1, bx2, by2, sb, cb);
        r = '0;
        if (sa == sb)
        begin
            r.parallel = 1'b1;
            return r;
        end
        px = qdiv(qsub(cb, ca), qsub(sa, sb));
        py = qadd(qmul(px, sa), ca);
        r.hit = in_range(px, ax1, ax2) && in_range(py, ay1, ay2) &&
                in_range(px, bx1, bx2) && in_range(py, by1, by2);
        clip = 1'b0;
        r.cx = narrow(px, clip);
        r.cy = narrow(py, clip);
        r.clamped = clip;
        return r;
    endfunction

    // ---- stimulus ----
    function automatic coord_t rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return $urandom_range(0, 1) ? C_MAX : C_MIN;
        if (k < 4) return coord_t'($urandom);
        // small coordinates, on the integer grid or on a grid of 1/16
        return coord_t'($signed($urandom_range(0, 64)) - 32) <<< ($urandom_range(0, 1) ? FB : 12);
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t s;
        int k;
        s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        k = $urandom_range(0, 9);
        if (k == 0) s.ax2 = s.ax1;                      // vertical
        else if (k == 1) begin s.ax2 = s.ax1; s.ay2 = s.ay1; end
        else if (k == 2)
        begin
            // same direction as segment a, so parallel
            s.bx2 = s.bx1 + (s.ax2 - s.ax1);
            s.by2 = s.by1 + (s.ay2 - s.ay1);
        end
        return s;
    endfunction

    // valid stays high into the next word when there is no idle gap
    task automatic send_word(seg_pair_t s);
        int idle;
        idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (idle != 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        pair_ch.valid         <= 1'b1;
        pair_ch.seg_a_start_x <= s.ax1;
        pair_ch.seg_a_start_y <= s.ay1;
        pair_ch.seg_a_end_x   <= s.ax2;
        pair_ch.seg_a_end_y   <= s.ay2;
        pair_ch.seg_b_start_x <= s.bx1;
        pair_ch.seg_b_start_y <= s.by1;
        pair_ch.seg_b_end_x   <= s.bx2;
        pair_ch.seg_b_end_y   <= s.by2;
        @(posedge clk);
        while (!pair_ch.ready) @(posedge clk);
    endtask

    function automatic coord_t q(int v);
        return coord_t'(v) <<< FB;
    endfunction

    function automatic crossing_t outcome(logic h, logic p, coord_t x, coord_t y, logic c);
        crossing_t r;
        r.hit = h; r.parallel = p; r.cx = x; r.cy = y; r.clamped = c;
        return r;
    endfunction

    vec_t directed[$];

    task automatic add_vec(seg_pair_t s, logic fixed, crossing_t r);
        vec_t v;
        v.pr = s; v.fixed = fixed; v.res = r;
        directed.push_back(v);
    endtask

    initial
    begin
        crossing_t none;
        none = '0;
        // plain x crossing at the origin
        add_vec({q(-1), q(-1), q(1), q(1), q(-1), q(1), q(1), q(-1)}, 1,
                outcome(1, 0, 0, 0, 0));
        // same lines shifted: parallel
        add_vec({q(0), q(0), q(2), q(2), q(0), q(1), q(2), q(3)}, 1,
                outcome(0, 1, 0, 0, 0));
        // both horizontal: parallel
        add_vec({q(0), q(0), q(5), q(0), q(0), q(3), q(5), q(3)}, 1,
                outcome(0, 1, 0, 0, 0));
        // crossing beyond segment a
        add_vec({q(0), q(0), q(1), q(1), q(4), q(0), q(4), q(8)}, 0, none);
        // vertical against horizontal
        add_vec({q(2), q(-3), q(2), q(3), q(-5), q(1), q(5), q(1)}, 0, none);
        // two vertical segments of equal length
        add_vec({q(1), q(0), q(1), q(4), q(3), q(0), q(3), q(4)}, 0, none);
        // degenerate point on a line
        add_vec({q(1), q(1), q(1), q(1), q(0), q(1), q(3), q(1)}, 0, none);
        // extremes of the coordinate range
        add_vec({C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN}, 0, none);
        add_vec({C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN}, 0, none);
        add_vec({coord_t'(0), C_MIN, coord_t'(0), C_MAX, C_MIN, coord_t'(1),
                 C_MAX, coord_t'(0)}, 0, none);
        // nearly parallel steep lines: crossing far away, clamped
        add_vec({q(0), q(0), coord_t'(1), q(1000), q(1), q(0), q(1) + 1, q(999)}, 0, none);
        add_vec({coord_t'(32'h5555_aaaa), coord_t'(32'haaaa_5555), coord_t'(-1),
                 coord_t'(1), coord_t'(1), coord_t'(-1), coord_t'(32'h0f0f_0f0f),
                 coord_t'(32'hf0f0_f0f0)}, 0, none);
        // all zero
        add_vec('0, 1, outcome(0, 1, 0, 0, 0));
    end

    initial
    begin
        seg_pair_t s;
        rst_n = 1'b0;
        stim_done = 1'b0;
        pair_ch.valid = 1'b0;
        {pair_ch.seg_a_start_x, pair_ch.seg_a_start_y, pair_ch.seg_a_end_x,
         pair_ch.seg_a_end_y, pair_ch.seg_b_start_x, pair_ch.seg_b_start_y,
         pair_ch.seg_b_end_x, pair_ch.seg_b_end_y} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            pending_crossings.push_back(directed[i].fixed ? directed[i].res
                                                          : predict_crossing(directed[i].pr));
            send_word(directed[i].pr);
        end
        pair_ch.valid <= 1'b0;
        // hold off until the pipeline has drained
        while (pending_crossings.size() != 0) @(posedge clk);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            s = rand_pair();
            pending_crossings.push_back(predict_crossing(s));
            send_word(s);
        end
        pair_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random stalls, then compare against the oldest expectation
    initial
    begin
        crossing_t got;
        crossing_t want;
        int stall;
        mismatches = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got = outcome(res_ch.hit, res_ch.parallel, res_ch.cross_x, res_ch.cross_y,
                          res_ch.clamped);
            if (pending_crossings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected hit=%0b par=%0b x=%0d y=%0d clamp=%0b",
                                 want.hit, want.parallel, want.cx, want.cy, want.clamped);
                        $display("          got      hit=%0b par=%0b x=%0d y=%0d clamp=%0b",
                                 got.hit, got.parallel, got.cx, got.cy, got.clamped);
                    end
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        @(posedge rst_n);
        while (!(stim_done && pending_crossings.size() == 0) && cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 20) @(posedge clk);
            if (mismatches == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
            $finish;
        end
    end

endmodule
